// ===== rtl/lnp_pkg.sv =====
// Shared constants, types and datapath select codes for the next-permutation block.
// No dependencies; every other file in rtl/ uses this package.

package lnp_pkg;

   localparam int MAX_LEN    = 8;
   localparam int ELEM_WIDTH = 16;
   localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W      = $clog2(MAX_LEN + 1);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic [1:0]                   sel_type;

   // read address select
   localparam sel_type RD_IDX = 2'd0;
   localparam sel_type RD_LO  = 2'd1;
   localparam sel_type RD_HI  = 2'd2;

   // write address select
   localparam sel_type WA_IDX = 2'd0;
   localparam sel_type WA_PIV = 2'd1;
   localparam sel_type WA_LO  = 2'd2;
   localparam sel_type WA_HI  = 2'd3;

   // write data select
   localparam sel_type WD_A  = 2'd0;
   localparam sel_type WD_B  = 2'd1;
   localparam sel_type WD_RD = 2'd2;

   typedef struct packed {
      logic    load;
      sel_type rd_sel;
      logic    wr_en;
      sel_type wr_sel;
      sel_type wd_sel;
      logic    idx_clr;
      logic    idx_top;
      logic    idx_dec;
      logic    idx_inc;
      logic    a_ld;
      logic    piv_ld;
      logic    set_exh;
      logic    rev_init;
      logic    rev_step;
      logic    out_elem;
      logic    out_exh;
   } cmd_type;

   typedef struct packed {
      logic adv_ok;
      logic out_free;
      logic lt;
      logic gt;
      logic idx_zero;
      logic idx_last;
      logic lo_lt_hi;
   } sts_type;

endpackage

// ===== rtl/lnp_req_if.sv =====
// Request channel: valid/ready handshake carrying op, value and is_last.
// Depends on lnp_pkg.

interface lnp_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   lnp_pkg::elem_type value;
   logic              is_last;

   modport source (output valid, output op, output value, output is_last, input ready);
   modport sink   (input valid, input op, input value, input is_last, output ready);
endinterface

// ===== rtl/lnp_rsp_if.sv =====
// Response channel: valid/ready handshake carrying element, end_of_run and status.
// Depends on lnp_pkg.

interface lnp_rsp_if;
   logic              valid;
   logic              ready;
   lnp_pkg::elem_type element;
   logic              end_of_run;
   logic              status;

   modport source (output valid, output element, output end_of_run, output status,
                   input ready);
   modport sink   (input valid, input element, input end_of_run, input status,
                   output ready);
endinterface

// ===== rtl/lnp_ctrl.sv =====
// Sequencer for loading, pivot/successor scans, swap, tail reversal and emission.
// Depends on lnp_pkg; drives the command bundle of lnp_dp.

module lnp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   input  logic             req_is_last,
   output logic             req_ready,
   input  lnp_pkg::sts_type sts,
   output lnp_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_EXH    = 5'd1;
   localparam logic [4:0] S_EM_RD  = 5'd2;
   localparam logic [4:0] S_EM_WR  = 5'd3;
   localparam logic [4:0] S_PV_RD0 = 5'd4;
   localparam logic [4:0] S_PV_A   = 5'd5;
   localparam logic [4:0] S_PV_RD  = 5'd6;
   localparam logic [4:0] S_PV_CMP = 5'd7;
   localparam logic [4:0] S_SC_RD  = 5'd8;
   localparam logic [4:0] S_SC_CMP = 5'd9;
   localparam logic [4:0] S_SW1    = 5'd10;
   localparam logic [4:0] S_SW2    = 5'd11;
   localparam logic [4:0] S_RV_CHK = 5'd12;
   localparam logic [4:0] S_RV_RL  = 5'd13;
   localparam logic [4:0] S_RV_RH  = 5'd14;
   localparam logic [4:0] S_RV_WL  = 5'd15;
   localparam logic [4:0] S_RV_WH  = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_op) begin
                  cmd.load = 1'b1;
                  if (req_is_last) begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_EM_RD;
                  end
               end else if (sts.adv_ok) begin
                  cmd.idx_top = 1'b1;
                  state_in    = S_PV_RD0;
               end else begin
                  state_in = S_EXH;
               end
            end
         end
         S_EXH: begin
            if (sts.out_free) begin
               cmd.out_exh = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EM_RD: begin
            cmd.rd_sel = lnp_pkg::RD_IDX;
            state_in   = S_EM_WR;
         end
         S_EM_WR: begin
            // hold the read address so the data stays put while stalled
            cmd.rd_sel = lnp_pkg::RD_IDX;
            if (sts.out_free) begin
               cmd.out_elem = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_EM_RD;
               end
            end
         end
         S_PV_RD0: begin
            cmd.rd_sel = lnp_pkg::RD_IDX;
            state_in   = S_PV_A;
         end
         S_PV_A: begin
            cmd.a_ld    = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = S_PV_RD;
         end
         S_PV_RD: begin
            cmd.rd_sel = lnp_pkg::RD_IDX;
            state_in   = S_PV_CMP;
         end
         S_PV_CMP: begin
            if (sts.lt) begin
               cmd.piv_ld  = 1'b1;
               cmd.idx_top = 1'b1;
               state_in    = S_SC_RD;
            end else begin
               cmd.a_ld = 1'b1;
               if (sts.idx_zero) begin
                  cmd.set_exh = 1'b1;
                  state_in    = S_EXH;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = S_PV_RD;
               end
            end
         end
         S_SC_RD: begin
            cmd.rd_sel = lnp_pkg::RD_IDX;
            state_in   = S_SC_CMP;
         end
         S_SC_CMP: begin
            if (sts.gt) begin
               cmd.a_ld = 1'b1;
               state_in = S_SW1;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = S_SC_RD;
            end
         end
         S_SW1: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = lnp_pkg::WA_IDX;
            cmd.wd_sel   = lnp_pkg::WD_B;
            cmd.rev_init = 1'b1;
            state_in     = S_SW2;
         end
         S_SW2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = lnp_pkg::WA_PIV;
            cmd.wd_sel = lnp_pkg::WD_A;
            state_in   = S_RV_CHK;
         end
         S_RV_CHK: begin
            if (sts.lo_lt_hi) begin
               state_in = S_RV_RL;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_EM_RD;
            end
         end
         S_RV_RL: begin
            cmd.rd_sel = lnp_pkg::RD_LO;
            state_in   = S_RV_RH;
         end
         S_RV_RH: begin
            cmd.a_ld   = 1'b1;
            cmd.rd_sel = lnp_pkg::RD_HI;
            state_in   = S_RV_WL;
         end
         S_RV_WL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = lnp_pkg::WA_LO;
            cmd.wd_sel = lnp_pkg::WD_RD;
            state_in   = S_RV_WH;
         end
         S_RV_WH: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = lnp_pkg::WA_HI;
            cmd.wd_sel   = lnp_pkg::WD_A;
            cmd.rev_step = 1'b1;
            state_in     = S_RV_CHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/lnp_dp.sv =====
// Datapath: element memory, count and flags, scan/swap registers, response register.
// Depends on lnp_pkg; commanded by lnp_ctrl.

module lnp_dp (
   input  logic              clock,
   input  logic              reset,
   input  lnp_pkg::cmd_type  cmd,
   output lnp_pkg::sts_type  sts,
   input  lnp_pkg::elem_type req_value,
   input  logic              req_is_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lnp_pkg::elem_type rsp_element,
   output logic              rsp_end_of_run,
   output logic              rsp_status
);

   lnp_pkg::elem_type elem_mem [lnp_pkg::MAX_LEN];
   lnp_pkg::elem_type rd_data_ff;
   lnp_pkg::elem_type a_ff;
   lnp_pkg::elem_type b_ff;
   lnp_pkg::cnt_type  cnt_ff;
   lnp_pkg::cnt_type  cnt_in;
   logic              done_ff;
   logic              done_in;
   logic              exh_ff;
   logic              exh_in;
   lnp_pkg::idx_type  idx_ff;
   lnp_pkg::idx_type  piv_ff;
   lnp_pkg::idx_type  lo_ff;
   lnp_pkg::idx_type  hi_ff;
   logic              out_valid_ff;
   lnp_pkg::elem_type out_elem_ff;
   logic              out_eor_ff;
   logic              out_status_ff;

   lnp_pkg::cnt_type  cnt_m1;
   lnp_pkg::idx_type  top_idx;
   lnp_pkg::cnt_type  base_cnt;
   logic              room;
   lnp_pkg::idx_type  rd_addr;
   lnp_pkg::idx_type  wr_addr;
   lnp_pkg::elem_type wr_data;
   logic              wr_en;

   assign cnt_m1  = cnt_ff - lnp_pkg::CNT_W'(1);
   assign top_idx = cnt_m1[lnp_pkg::IDX_W-1:0];

   // a load after a completed array starts again from an empty one
   assign base_cnt = done_ff ? '0 : cnt_ff;
   assign room     = (base_cnt < lnp_pkg::CNT_W'(lnp_pkg::MAX_LEN));

   always_comb begin
      case (cmd.rd_sel)
         lnp_pkg::RD_LO: rd_addr = lo_ff;
         lnp_pkg::RD_HI: rd_addr = hi_ff;
         default:        rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      wr_en   = cmd.wr_en;
      wr_addr = idx_ff;
      case (cmd.wd_sel)
         lnp_pkg::WD_B:  wr_data = b_ff;
         lnp_pkg::WD_RD: wr_data = rd_data_ff;
         default:        wr_data = a_ff;
      endcase
      case (cmd.wr_sel)
         lnp_pkg::WA_PIV: wr_addr = piv_ff;
         lnp_pkg::WA_LO:  wr_addr = lo_ff;
         lnp_pkg::WA_HI:  wr_addr = hi_ff;
         default:         wr_addr = idx_ff;
      endcase
      if (cmd.load) begin
         wr_en   = room;
         wr_addr = base_cnt[lnp_pkg::IDX_W-1:0];
         wr_data = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         elem_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= elem_mem[rd_addr];
   end

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      exh_in  = exh_ff;
      if (cmd.load) begin
         cnt_in = room ? (base_cnt + lnp_pkg::CNT_W'(1)) : base_cnt;
         if (done_ff) begin
            done_in = 1'b0;
            exh_in  = 1'b1;
         end
         if (req_is_last) begin
            done_in = 1'b1;
            exh_in  = (cnt_in < lnp_pkg::CNT_W'(2));
         end
      end
      if (cmd.set_exh) begin
         exh_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         exh_ff  <= 1'b1;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         exh_ff  <= exh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_top) begin
         idx_ff <= top_idx;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - lnp_pkg::IDX_W'(1);
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + lnp_pkg::IDX_W'(1);
      end
      if (cmd.a_ld) begin
         a_ff <= rd_data_ff;
      end
      if (cmd.piv_ld) begin
         piv_ff <= idx_ff;
         b_ff   <= rd_data_ff;
      end
      if (cmd.rev_init) begin
         lo_ff <= piv_ff + lnp_pkg::IDX_W'(1);
         hi_ff <= top_idx;
      end else if (cmd.rev_step) begin
         lo_ff <= lo_ff + lnp_pkg::IDX_W'(1);
         hi_ff <= hi_ff - lnp_pkg::IDX_W'(1);
      end
   end

   // response register: refill when empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_elem || cmd.out_exh) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_elem) begin
         out_elem_ff   <= rd_data_ff;
         out_eor_ff    <= sts.idx_last;
         out_status_ff <= 1'b0;
      end else if (cmd.out_exh) begin
         out_elem_ff   <= '0;
         out_eor_ff    <= 1'b0;
         out_status_ff <= 1'b1;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_element    = out_elem_ff;
   assign rsp_end_of_run = out_eor_ff;
   assign rsp_status     = out_status_ff;

   assign sts.adv_ok   = done_ff && !exh_ff && (cnt_ff >= lnp_pkg::CNT_W'(2));
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign sts.lt       = (rd_data_ff < a_ff);
   assign sts.gt       = (rd_data_ff > b_ff);
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.idx_last = (lnp_pkg::CNT_W'(idx_ff) == cnt_m1);
   assign sts.lo_lt_hi = (lo_ff < hi_ff);

endmodule

// ===== rtl/lexicographic_next_permutation.sv =====
// Next lexicographic permutation engine. Load requests each write one element, while there
// is room, into an eight-entry memory with one write port and one registered read port.
// A load flagged last, and each advance that yields a permutation, emit the array one
// element per response. An advance first scans down from the top for the pivot and then
// for its successor, swaps them, then reverses the tail by swapping pairs from both ends
// inward, with every element read going through the single read port of the memory.
// An advance that finds no ascent, or follows one that found none, or comes before a
// complete array of two or more elements, gives one response with status set. A new
// request is taken as soon as the sequencer is idle, while the last response may still
// wait in the output register.
// Depends on lnp_pkg, lnp_req_if, lnp_rsp_if, lnp_ctrl and lnp_dp.

module lexicographic_next_permutation (
   input  logic       clock,
   input  logic       reset,
   lnp_req_if.sink    req_chan,
   lnp_rsp_if.source  rsp_chan
);

   lnp_pkg::cmd_type cmd;
   lnp_pkg::sts_type sts;

   lnp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_op      (req_chan.op),
      .req_is_last (req_chan.is_last),
      .req_ready   (req_chan.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   lnp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_value      (req_chan.value),
      .req_is_last    (req_chan.is_last),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_element    (rsp_chan.element),
      .rsp_end_of_run (rsp_chan.end_of_run),
      .rsp_status     (rsp_chan.status)
   );

endmodule
